// ----- sv/pdbp_pkg.sv -----
// ----------------------------------------------------------------------------
// pdbp_pkg
// Shared types and constants for the packet double-block placer.
// ----------------------------------------------------------------------------
package pdbp_pkg;

  // field widths fixed by the descriptor format
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned FILL_W  = 31;
  localparam int unsigned ADDR_W  = 30;
  localparam int unsigned PLACE_W = 3;

  localparam logic [FILL_W-1:0] FILL_MAX         = {FILL_W{1'b1}};
  localparam logic [FILL_W-1:0] BLOCK_SIZE_RESET = 31'd134217728;

  // placement codes
  typedef enum logic [PLACE_W-1:0] {
    PLACE_CURRENT = 3'd0,
    PLACE_NEXT    = 3'd1,
    PLACE_LATE    = 3'd2,
    PLACE_AHEAD   = 3'd3,
    PLACE_SHORT   = 3'd4
  } placement_t;

  // window bookkeeping that does not depend on the offset width
  typedef struct packed {
    logic [FILL_W-1:0] current_fill;
    logic [FILL_W-1:0] next_fill;
    logic              advance_pending;
  } fill_state_t;

  // one result item
  typedef struct packed {
    placement_t        placement;
    logic [ADDR_W-1:0] write_address;
    logic              window_advanced;
    logic              drop_report;
    logic [FILL_W-1:0] dropped_count;
  } result_t;

endpackage

// ----- sv/pdbp_classify.sv -----
// ----------------------------------------------------------------------------
// pdbp_classify
// Classifies one packet against the two-block window and computes the
// result item and the next window state.
// ----------------------------------------------------------------------------
module pdbp_classify #(
  parameter int unsigned OFFSET_WIDTH = 48
) (
  input  logic [OFFSET_WIDTH-1:0]           window_start,
  input  pdbp_pkg::fill_state_t             fill,
  input  logic [pdbp_pkg::FILL_W-1:0]       block_bytes,
  input  logic [pdbp_pkg::FILL_W+1:0]       block_bytes_x3,
  input  logic [OFFSET_WIDTH-1:0]           offset,
  input  logic [pdbp_pkg::LEN_W-1:0]        len,
  input  logic                              is_short,
  output logic [OFFSET_WIDTH-1:0]           window_start_next,
  output pdbp_pkg::fill_state_t             fill_next,
  output pdbp_pkg::result_t                 result
);

  localparam int unsigned XW = OFFSET_WIDTH + 2;
  localparam logic [XW-1:0] WRAP = {2'b01, {OFFSET_WIDTH{1'b0}}};

  logic [XW-1:0] bs_x;
  logic [XW-1:0] bs2_x;
  logic [XW-1:0] bs3_x;
  logic [XW-1:0] ws_x;
  logic [XW-1:0] off_x;
  logic [XW-1:0] end1;
  logic [XW-1:0] end2;
  logic [XW-1:0] end3;
  logic [XW-1:0] cur_end;
  logic [XW-1:0] next_end;
  logic [OFFSET_WIDTH-1:0] base;
  logic          adv;
  logic          wrapped;
  logic          in_cur;
  logic          in_next;
  logic          late;
  logic [pdbp_pkg::FILL_W-1:0] cf0;
  logic [pdbp_pkg::FILL_W-1:0] nf0;
  logic [pdbp_pkg::FILL_W:0]   cf_sum;
  logic [pdbp_pkg::FILL_W:0]   nf_sum;
  logic [pdbp_pkg::FILL_W-1:0] cf1;
  logic [pdbp_pkg::FILL_W-1:0] nf1;
  logic          report;

  // widened operands
  assign bs_x  = {{(XW-pdbp_pkg::FILL_W){1'b0}}, block_bytes};
  assign bs2_x = {{(XW-pdbp_pkg::FILL_W-1){1'b0}}, block_bytes, 1'b0};
  assign bs3_x = {{(XW-pdbp_pkg::FILL_W-2){1'b0}}, block_bytes_x3};
  assign ws_x  = {2'b00, window_start};
  assign off_x = {2'b00, offset};

  // window bounds for both the held and the advanced window, in parallel
  assign end1 = ws_x + bs_x;
  assign end2 = ws_x + bs2_x;
  assign end3 = ws_x + bs3_x;

  assign adv     = fill.advance_pending;
  assign wrapped = adv & end1[OFFSET_WIDTH];
  assign base    = adv ? end1[OFFSET_WIDTH-1:0] : window_start;

  // the advanced start wraps, its bounds do not
  always_comb begin
    if (adv) begin
      cur_end  = wrapped ? (end2 - WRAP) : end2;
      next_end = wrapped ? (end3 - WRAP) : end3;
    end else begin
      cur_end  = end1;
      next_end = end2;
    end
  end

  // range tests
  assign in_cur  = (offset >= base) && (off_x < cur_end);
  assign in_next = !in_cur && (off_x >= cur_end) && (off_x < next_end);
  assign late    = !in_cur && !in_next && (offset < base);

  // fill counts after the advance, then after placing this packet
  assign cf0    = adv ? fill.next_fill : fill.current_fill;
  assign nf0    = adv ? '0 : fill.next_fill;
  assign cf_sum = {1'b0, cf0} + {{(pdbp_pkg::FILL_W+1-pdbp_pkg::LEN_W){1'b0}}, len};
  assign nf_sum = {1'b0, nf0} + {{(pdbp_pkg::FILL_W+1-pdbp_pkg::LEN_W){1'b0}}, len};

  always_comb begin
    cf1 = cf0;
    nf1 = nf0;
    if (in_cur) begin
      cf1 = cf_sum[pdbp_pkg::FILL_W] ? pdbp_pkg::FILL_MAX : cf_sum[pdbp_pkg::FILL_W-1:0];
    end
    if (in_next) begin
      nf1 = nf_sum[pdbp_pkg::FILL_W] ? pdbp_pkg::FILL_MAX : nf_sum[pdbp_pkg::FILL_W-1:0];
    end
  end

  // drop report: current full, next half full, or a packet ahead of the window
  assign report = (cf1 >= block_bytes) || (nf1 >= (block_bytes >> 1)) ||
                  (!in_cur && !in_next && !late);

  // result and next state
  always_comb begin
    result            = '0;
    window_start_next = window_start;
    fill_next         = fill;
    if (is_short) begin
      result.placement = pdbp_pkg::PLACE_SHORT;
    end else begin
      window_start_next         = base;
      fill_next.current_fill    = cf1;
      fill_next.next_fill       = nf1;
      fill_next.advance_pending = report;
      result.window_advanced    = adv;
      if (in_cur) begin
        result.placement     = pdbp_pkg::PLACE_CURRENT;
        result.write_address = offset[pdbp_pkg::ADDR_W-1:0] - base[pdbp_pkg::ADDR_W-1:0];
      end else if (in_next) begin
        result.placement     = pdbp_pkg::PLACE_NEXT;
        result.write_address = offset[pdbp_pkg::ADDR_W-1:0] - cur_end[pdbp_pkg::ADDR_W-1:0];
      end else if (late) begin
        result.placement = pdbp_pkg::PLACE_LATE;
      end else begin
        result.placement = pdbp_pkg::PLACE_AHEAD;
      end
      if (report) begin
        result.drop_report   = 1'b1;
        result.dropped_count = (block_bytes > cf1) ? (block_bytes - cf1) : '0;
      end
    end
  end

endmodule

// ----- sv/packet_double_block_placer.sv -----
// A packet passes through the input register and then the result register.
// Throughput: one packet per cycle while out_stall is low; the window state is
// updated in the single pass between the input register and the result register.
// Reset (synchronous): clears the window, both fill counts, the pending
// advance and all valid flags; the block size register returns to 134217728.
// ----------------------------------------------------------------------------
// packet_double_block_placer
// Two-block reorder window: places packets in the current or next block,
// flags late, ahead and short packets, and reports dropped bytes.
// ----------------------------------------------------------------------------
module packet_double_block_placer #(
  parameter int unsigned OFFSET_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  // packet descriptors
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [OFFSET_WIDTH-1:0]           stream_offset,
  input  logic [pdbp_pkg::LEN_W-1:0]        payload_bytes,
  input  logic                              short_packet,
  // placement results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pdbp_pkg::PLACE_W-1:0]      placement,
  output logic [pdbp_pkg::ADDR_W-1:0]       write_address,
  output logic                              window_advanced,
  output logic                              drop_report,
  output logic [pdbp_pkg::FILL_W-1:0]       dropped_count,
  // block size register
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdbp_pkg::FILL_W-1:0]       block_size
);

  localparam logic [pdbp_pkg::FILL_W+1:0] BS3_RESET =
    {2'b00, pdbp_pkg::BLOCK_SIZE_RESET} + {1'b0, pdbp_pkg::BLOCK_SIZE_RESET, 1'b0};

  logic [pdbp_pkg::FILL_W-1:0]   block_bytes;
  logic [pdbp_pkg::FILL_W+1:0]   block_bytes_x3;
  logic [OFFSET_WIDTH-1:0]       window_start;
  logic [OFFSET_WIDTH-1:0]       window_start_next;
  pdbp_pkg::fill_state_t         fill;
  pdbp_pkg::fill_state_t         fill_next;
  pdbp_pkg::result_t             cls_result;
  pdbp_pkg::result_t             result;

  logic                          s1_valid;
  logic [OFFSET_WIDTH-1:0]       s1_offset;
  logic [pdbp_pkg::LEN_W-1:0]    s1_len;
  logic                          s1_short;

  logic                          s2_free;
  logic                          s1_fire;
  logic                          in_take;

  // handshake
  assign s2_free   = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && s2_free;
  assign in_stall  = s1_valid && !s2_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // block size register and its triple for the advanced window bound
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes    <= pdbp_pkg::BLOCK_SIZE_RESET;
      block_bytes_x3 <= BS3_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_bytes    <= block_size;
      block_bytes_x3 <= {2'b00, block_size} + {1'b0, block_size, 1'b0};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_offset <= stream_offset;
      s1_len    <= payload_bytes;
      s1_short  <= short_packet;
    end
  end

  // classification
  pdbp_classify #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_classify (
    .window_start      (window_start),
    .fill              (fill),
    .block_bytes       (block_bytes),
    .block_bytes_x3    (block_bytes_x3),
    .offset            (s1_offset),
    .len               (s1_len),
    .is_short          (s1_short),
    .window_start_next (window_start_next),
    .fill_next         (fill_next),
    .result            (cls_result)
  );

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      fill         <= '0;
    end else if (s1_fire) begin
      window_start <= window_start_next;
      fill         <= fill_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= cls_result;
    end
  end

  assign placement       = result.placement;
  assign write_address   = result.write_address;
  assign window_advanced = result.window_advanced;
  assign drop_report     = result.drop_report;
  assign dropped_count   = result.dropped_count;

`ifndef SYNTHESIS
  // a short packet never moves the window
  a_short_no_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && (placement == pdbp_pkg::PLACE_SHORT) |-> !window_advanced && !drop_report)
    else $error("short packet result carries window activity");

  // no dropped bytes without a drop report
  a_drop_gated: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drop_report |-> dropped_count == '0)
    else $error("dropped count without drop report");

  // a reported drop arms the advance for the next full packet
  a_report_arms: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_short |=> fill.advance_pending == $past(cls_result.drop_report))
    else $error("advance pending does not follow drop report");

  // a full-size packet with a pending advance reports the move
  a_advance_seen: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_short && fill.advance_pending |=> window_advanced)
    else $error("pending advance not reported");
`endif

endmodule

// ----- sim/pdbp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdbp_checker
// Watches the packet, result and block-size channels of the placer, keeps
// its own copy of the two-block window and compares every result with the
// placement it predicts.
// ----------------------------------------------------------------------------
module pdbp_checker #(
  parameter int unsigned OFS_W = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [OFS_W-1:0]             stream_offset,
  input  logic [pdbp_pkg::LEN_W-1:0]   payload_bytes,
  input  logic                         short_packet,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [pdbp_pkg::PLACE_W-1:0] placement,
  input  logic [pdbp_pkg::ADDR_W-1:0]  write_address,
  input  logic                         window_advanced,
  input  logic                         drop_report,
  input  logic [pdbp_pkg::FILL_W-1:0]  dropped_count,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [pdbp_pkg::FILL_W-1:0]  block_size,
  output int                           fail_count,
  output int                           outstanding,
  output int                           packets_checked,
  output int                           advances_seen,
  output int                           drops_seen,
  output logic [OFS_W-1:0]             window_base,
  output logic                         advance_due
);

  // predicted window state
  logic [pdbp_pkg::FILL_W-1:0] blk_size;
  logic [OFS_W-1:0]            win_start;
  logic [pdbp_pkg::FILL_W-1:0] cur_fill;
  logic [pdbp_pkg::FILL_W-1:0] nxt_fill;
  logic                        adv_pending;

  // placements predicted but not yet seen on the result channel
  pdbp_pkg::result_t pending_placements[$];

  // fill counts stick at the top of their range
  function automatic logic [pdbp_pkg::FILL_W-1:0] sat_add(
      input logic [pdbp_pkg::FILL_W-1:0] fill,
      input logic [pdbp_pkg::LEN_W-1:0]  len);
    logic [pdbp_pkg::FILL_W:0] sum;
    sum = {1'b0, fill} + {{(pdbp_pkg::FILL_W+1-pdbp_pkg::LEN_W){1'b0}}, len};
    return (sum > {1'b0, pdbp_pkg::FILL_MAX}) ? pdbp_pkg::FILL_MAX
                                             : sum[pdbp_pkg::FILL_W-1:0];
  endfunction

  // classify one packet and update the window
  function automatic pdbp_pkg::result_t place_packet(
      input logic [OFS_W-1:0]           off,
      input logic [pdbp_pkg::LEN_W-1:0] len,
      input logic                       is_short);
    pdbp_pkg::result_t res;
    logic [63:0] pos;
    logic [63:0] cur_end;
    logic [63:0] nxt_end;
    logic [63:0] rel;
    logic        ahead;
    res = '0;
    ahead = 1'b0;
    if (is_short) begin
      res.placement = pdbp_pkg::PLACE_SHORT;
    end else begin
      // a pending advance moves the window by the block size now in force
      if (adv_pending) begin
        adv_pending = 1'b0;
        win_start = win_start + OFS_W'(blk_size);
        cur_fill = nxt_fill;
        nxt_fill = '0;
        res.window_advanced = 1'b1;
      end
      // window bounds are compared without wrap
      pos = 64'(off);
      cur_end = 64'(win_start) + 64'(blk_size);
      nxt_end = cur_end + 64'(blk_size);
      if (pos >= 64'(win_start) && pos < cur_end) begin
        res.placement = pdbp_pkg::PLACE_CURRENT;
        rel = pos - 64'(win_start);
        res.write_address = rel[pdbp_pkg::ADDR_W-1:0];
        cur_fill = sat_add(cur_fill, len);
      end else if (pos >= cur_end && pos < nxt_end) begin
        res.placement = pdbp_pkg::PLACE_NEXT;
        rel = pos - cur_end;
        res.write_address = rel[pdbp_pkg::ADDR_W-1:0];
        nxt_fill = sat_add(nxt_fill, len);
      end else if (pos < 64'(win_start)) begin
        res.placement = pdbp_pkg::PLACE_LATE;
      end else begin
        res.placement = pdbp_pkg::PLACE_AHEAD;
        ahead = 1'b1;
      end
      // full block, half-full next block or an ahead packet closes the block
      if (cur_fill >= blk_size || nxt_fill >= (blk_size >> 1) || ahead) begin
        res.drop_report = 1'b1;
        res.dropped_count = (blk_size > cur_fill) ? blk_size - cur_fill : '0;
        adv_pending = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    if (fail_count < 40)
      $display("%0t ns: %s got %0h expected %0h", $time, what, got_v, want_v);
    fail_count++;
  endtask

  // one pass per edge: results first, then register writes, then packets
  always @(posedge clk) begin : watch
    pdbp_pkg::result_t want;
    if (rst) begin
      blk_size = pdbp_pkg::BLOCK_SIZE_RESET;
      win_start = '0;
      cur_fill = '0;
      nxt_fill = '0;
      adv_pending = 1'b0;
      pending_placements.delete();
      fail_count = 0;
      packets_checked = 0;
      advances_seen = 0;
      drops_seen = 0;
    end else begin
      // result transaction
      if (out_valid && !out_stall) begin
        if (pending_placements.size() == 0) begin
          report_mismatch("result with no packet outstanding, placement",
                          64'(placement), 64'd0);
        end else begin
          want = pending_placements.pop_front();
          if (placement !== want.placement)
            report_mismatch("placement", 64'(placement), 64'(want.placement));
          if (write_address !== want.write_address)
            report_mismatch("write_address", 64'(write_address),
                            64'(want.write_address));
          if (window_advanced !== want.window_advanced)
            report_mismatch("window_advanced", 64'(window_advanced),
                            64'(want.window_advanced));
          if (drop_report !== want.drop_report)
            report_mismatch("drop_report", 64'(drop_report), 64'(want.drop_report));
          if (dropped_count !== want.dropped_count)
            report_mismatch("dropped_count", 64'(dropped_count),
                            64'(want.dropped_count));
          packets_checked++;
          if (want.window_advanced)
            advances_seen++;
          if (want.drop_report)
            drops_seen++;
        end
      end
      // block size write
      if (cfg_valid && cfg_ready)
        blk_size = block_size;
      // packet transaction
      if (in_valid && !in_stall)
        pending_placements.push_back(place_packet(stream_offset, payload_bytes,
                                                  short_packet));
    end
    outstanding = pending_placements.size();
    window_base = win_start;
    advance_due = adv_pending;
  end

endmodule

// ----- sim/packet_double_block_placer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_double_block_placer_tb
// Drives packet descriptors and block-size writes into the placer with
// random packet gaps and output stalls; a checker beside it predicts each
// placement and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module packet_double_block_placer_tb;

  localparam int unsigned OFS_W       = 48;
  localparam int          CYCLE_LIMIT = 600000;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [OFS_W-1:0]              stream_offset;
  logic [pdbp_pkg::LEN_W-1:0]    payload_bytes;
  logic                          short_packet;
  logic                          out_valid;
  logic                          out_stall;
  logic [pdbp_pkg::PLACE_W-1:0]  placement;
  logic [pdbp_pkg::ADDR_W-1:0]   write_address;
  logic                          window_advanced;
  logic                          drop_report;
  logic [pdbp_pkg::FILL_W-1:0]   dropped_count;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pdbp_pkg::FILL_W-1:0]   block_size;

  int                            fail_count;
  int                            outstanding;
  int                            packets_checked;
  int                            advances_seen;
  int                            drops_seen;
  logic [OFS_W-1:0]              window_base;
  logic                          advance_due;

  int unsigned                   send_pct;
  int unsigned                   recv_pct;
  int                            settings_run;
  int                            cycle_count = 0;
  logic [pdbp_pkg::FILL_W-1:0]   cur_block;

  packet_double_block_placer #(
    .OFFSET_WIDTH(OFS_W)
  ) dut (.*);

  pdbp_checker #(
    .OFS_W(OFS_W)
  ) placement_checker (.*);

  always #5 clk = ~clk;

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, outstanding);
      $display("FAIL packet_double_block_placer");
      $finish;
    end
  end

  // start of the window that the next full-size packet will see
  function automatic logic [63:0] aim();
    return 64'(window_base) + (advance_due ? 64'(cur_block) : 64'd0);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rnd_below(input logic [63:0] lim);
    return (lim == 64'd0) ? 64'd0 : rnd64() % lim;
  endfunction

  function automatic logic [pdbp_pkg::LEN_W-1:0] rand_len(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(hi);
    return r[pdbp_pkg::LEN_W-1:0];
  endfunction

  // one packet transaction, with a random gap in front
  task automatic send_packet(input logic [63:0] off,
                             input logic [pdbp_pkg::LEN_W-1:0] len,
                             input logic shrt);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    stream_offset <= off[OFS_W-1:0];
    payload_bytes <= len;
    short_packet <= shrt;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  // block size changes only once the block has gone quiet
  task automatic write_block_size(input logic [pdbp_pkg::FILL_W-1:0] value);
    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    block_size <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_block = value;
    settings_run++;
  endtask

  // mostly an in-order stream near the window, with reordering, late,
  // ahead, short and fully random packets mixed in
  task automatic run_stream(input logic [pdbp_pkg::FILL_W-1:0] bsz, input int count);
    logic [63:0]                cursor;
    logic [63:0]                span;
    logic [pdbp_pkg::LEN_W-1:0] len;
    int unsigned                lenmax;
    int unsigned                pick;
    write_block_size(bsz);
    span = 64'(bsz);
    lenmax = 32'(bsz >> 2);
    if (lenmax < 1)
      lenmax = 1;
    if (lenmax > 65535)
      lenmax = 65535;
    cursor = aim();
    repeat (count) begin
      pick = $urandom_range(99);
      len = rand_len(lenmax);
      if (cursor < aim() || cursor >= aim() + (span << 1))
        cursor = aim() + rnd_below(span);
      if (pick < 6) begin
        send_packet(rnd64(), rand_len(32'hFFFF), 1'b1);
      end else if (pick < 12) begin
        send_packet(rnd64(), rand_len(32'hFFFF), 1'b0);
      end else if (pick < 70) begin
        send_packet(cursor, len, 1'b0);
        cursor = cursor + 64'(len);
      end else if (pick < 82) begin
        send_packet(cursor + rnd_below(span << 1), len, 1'b0);
      end else if (pick < 90) begin
        send_packet(cursor - rnd_below(span + 64'd1), len, 1'b0);
      end else begin
        send_packet(cursor + (span << 1) + rnd_below(span + 64'd1), len, 1'b0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    stream_offset = '0;
    payload_bytes = '0;
    short_packet = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    block_size = '0;
    cur_block = pdbp_pkg::BLOCK_SIZE_RESET;
    settings_run = 1;
    send_pct = 33;
    recv_pct = 65;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed packets against the reset block size
    send_packet(64'd0, 16'd0, 1'b0);
    send_packet(64'(pdbp_pkg::BLOCK_SIZE_RESET) - 64'd1, 16'hFFFF, 1'b0);
    send_packet(64'(pdbp_pkg::BLOCK_SIZE_RESET), 16'd1, 1'b0);
    send_packet((64'(pdbp_pkg::BLOCK_SIZE_RESET) << 1) - 64'd1, 16'd0, 1'b0);
    send_packet(rnd64(), rand_len(32'hFFFF), 1'b1);
    // ahead of the window, then a short packet while the advance is held
    send_packet(64'(pdbp_pkg::BLOCK_SIZE_RESET) << 1, 16'd8, 1'b0);
    send_packet(64'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    send_packet(64'(pdbp_pkg::BLOCK_SIZE_RESET) + 64'd3, 16'd4, 1'b0);
    send_packet(64'd5, 16'd2, 1'b0);
    send_packet(64'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
    send_packet(64'd0, 16'd0, 1'b0);

    // half-full next block, then a full current block
    write_block_size(31'd16);
    send_packet(aim() + 64'd16, 16'd8, 1'b0);
    send_packet(aim() + 64'd8, 16'd8, 1'b0);
    send_packet(aim(), 16'd0, 1'b0);

    run_stream(31'd16, 150);
    run_stream(31'd2, 100);
    run_stream(31'd1024, 150);

    send_pct = 65;
    recv_pct = 33;
    run_stream(31'd0, 40);
    run_stream(31'd3, 80);
    run_stream(31'd64, 200);
    run_stream(31'h4000_0000, 60);

    send_pct = 0;
    recv_pct = 0;
    run_stream(31'h7FFF_FFFF, 40);
    run_stream(31'd4096, 200);
    run_stream(31'd256, 200);
    run_stream(31'd100, 80);

    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);

    $display("checked %0d placements over %0d block sizes: %0d window moves, %0d drops",
             packets_checked, settings_run, advances_seen, drops_seen);
    if (fail_count == 0) begin
      $display("PASS packet_double_block_placer");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL packet_double_block_placer");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pdbp_pkg.sv
sv/pdbp_classify.sv
sv/packet_double_block_placer.sv
sim/pdbp_checker.sv
sim/packet_double_block_placer_tb.sv
